FILE: hw/rtl/bht_pkg.sv
// ----------------------------------------------------------------------------
// bht_pkg
// shared types, sizes and codes of the bucketed hash table
// ----------------------------------------------------------------------------
package bht_pkg;

  // table geometry
  localparam int BUCKETS  = 100;
  localparam int SLOTS    = 5;

  // field widths
  localparam int KEY_W    = 31;
  localparam int OP_W     = 2;
  localparam int PROBES_W = 3;

  // derived sizes
  localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IDX_W    = $clog2(SLOTS + 1);
  localparam int ROW_W    = SLOTS * KEY_W;

  // key mod BUCKETS by reciprocal multiply: q = (key * DIV_MUL) >> DIV_SH
  localparam int MUL_W    = KEY_W + 1;
  localparam int PROD_W   = KEY_W + MUL_W;
  localparam int DIV_SH   = KEY_W + ((BUCKETS > 1) ? $clog2(BUCKETS) : 0);
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'(((64'd1 << DIV_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  typedef logic [KEY_W-1:0]              key_t;
  typedef logic [SLOTS-1:0][KEY_W-1:0]   row_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    key_t            key;
  } in_t;

  typedef struct packed {
    logic [PROBES_W-1:0] probes;
    logic                success;
  } out_t;

  // row update status back to the sequencer
  typedef struct packed {
    logic wr_en;
    out_t res;
  } row_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EXEC
  } st_t;

endpackage

FILE: hw/rtl/bht_ram.sv
// ----------------------------------------------------------------------------
// bht_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module bht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/bht_bucket.sv
// ----------------------------------------------------------------------------
// bht_bucket
// two-step bucket index: registered reciprocal multiply, then remainder
// ----------------------------------------------------------------------------
module bht_bucket
  import bht_pkg::*;
(
  input  logic             clk,
  input  key_t             key,
  output logic [BKT_W-1:0] bucket
);

  logic [PROD_W-1:0] prod;
  key_t              quo_nxt;
  key_t              quo_r;
  key_t              bkt_k;
  key_t              qb;
  key_t              rem;
  key_t              rem_fix;

  assign bkt_k   = KEY_W'(BUCKETS);
  assign prod    = PROD_W'(key) * PROD_W'(DIV_MUL);
  assign quo_nxt = KEY_W'(prod >> DIV_SH);

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  // remainder, with one guard step
  assign qb      = quo_r * bkt_k;
  assign rem     = key - qb;
  assign rem_fix = (rem >= bkt_k) ? (rem - bkt_k) : rem;
  assign bucket  = rem_fix[BKT_W-1:0];

endmodule

FILE: hw/rtl/bht_row.sv
// ----------------------------------------------------------------------------
// bht_row
// slot compare and row update for insert, search and remove
// ----------------------------------------------------------------------------
module bht_row
  import bht_pkg::*;
(
  input  logic [OP_W-1:0] opcode,
  input  key_t            key,
  input  row_t            row_in,
  output row_t            row_out,
  output row_res_t        status
);

  logic             hit_found;
  logic             hit_match;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             gap_found;
  logic [IDX_W-1:0] gap_idx;
  logic [IDX_W:0]   hit_cnt;
  logic [IDX_W:0]   free_cnt;

  // priority scans over the slots
  always_comb begin
    hit_found  = 1'b0;
    hit_match  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    gap_found  = 1'b0;
    gap_idx    = IDX_W'(SLOTS);
    for (int k = 0; k < SLOTS; k++) begin
      if (!hit_found && (row_in[k] == key || row_in[k] == '0)) begin
        hit_found = 1'b1;
        hit_match = (row_in[k] == key);
        hit_idx   = IDX_W'(k);
      end
      if (!free_found && row_in[k] == '0) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(k);
      end
    end
    // first empty slot after the hit ends the shift
    for (int k = 0; k < SLOTS; k++) begin
      if (hit_found && !gap_found && k > int'(hit_idx) && row_in[k] == '0) begin
        gap_found = 1'b1;
        gap_idx   = IDX_W'(k);
      end
    end
  end

  assign hit_cnt  = {1'b0, hit_idx} + (IDX_W+1)'(1);
  assign free_cnt = {1'b0, free_idx} + (IDX_W+1)'(1);

  always_comb begin
    row_out = row_in;
    status  = '0;
    case (opcode) inside
      OP_INSERT: begin
        if (free_found) begin
          for (int k = 0; k < SLOTS; k++) begin
            if (k == int'(free_idx)) begin
              row_out[k] = key;
            end
          end
          status.wr_en       = 1'b1;
          status.res.probes  = PROBES_W'(free_cnt);
          status.res.success = 1'b1;
        end else begin
          status.res.probes  = PROBES_W'(SLOTS);
        end
      end
      OP_SEARCH, OP_REMOVE: begin
        if (hit_found) begin
          status.res.probes  = PROBES_W'(hit_cnt);
          status.res.success = hit_match;
          if (opcode == OP_REMOVE && hit_match) begin
            status.wr_en = 1'b1;
            // clear the hit and pull later occupied slots up one place
            for (int k = 0; k < SLOTS; k++) begin
              if (k >= int'(hit_idx)) begin
                if (k + 1 < int'(gap_idx)) begin
                  if (k < SLOTS - 1) begin
                    row_out[k] = row_in[k + 1];
                  end
                end else if (k + 1 == int'(gap_idx)) begin
                  row_out[k] = '0;
                end
              end
            end
          end
        end else begin
          status.res.probes  = PROBES_W'(SLOTS);
        end
      end
      default: begin
        status = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/bucketed_hash_table_top.sv
// ----------------------------------------------------------------------------
// bucketed_hash_table_top
// hash table of BUCKETS rows with SLOTS key slots per row
// ----------------------------------------------------------------------------
// usage
//   input beat: in_data (opcode, key) is taken at a rising edge with start
//   high and busy low. opcode insert fills the first empty slot of row
//   key mod BUCKETS, search stops at a match or the first empty slot,
//   remove clears the match and packs the rest of the row up one place.
//   result beat: out_data (probes, success) is shown for one cycle with
//   out_valid high. the receiver cannot stall; results are never held.
//   an accepted beat passes the states div (bucket multiply), read (row
//   read from the registered ram), exec (compare and write back), then
//   the idle state in which the result is shown; busy stays high until
//   then. busy falls while the result is shown, so a new beat can be
//   taken in that cycle.
//   each row is one ram word; a row valid flop per bucket makes rows read
//   as empty until first written, so reset needs no clearing pass.
//   reset (rst_n low, synchronous) empties the table and drops busy.
// ----------------------------------------------------------------------------
module bucketed_hash_table_top
  import bht_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  st_t              state_r;
  st_t              state_nxt;
  in_t              req_r;
  logic [BKT_W-1:0] bucket;
  logic [BKT_W-1:0] bucket_r;
  logic             row_ok_r;
  logic [BUCKETS-1:0] valid_r;
  logic             out_valid_r;
  out_t             out_data_r;

  logic             accept;
  logic             ram_re;
  logic             ram_we;
  logic [ROW_W-1:0] ram_rdata;
  row_t             row_cur;
  row_t             row_new;
  row_res_t         row_st;

  assign accept = start && (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy   = 1'b1;
    ram_re = 1'b0;
    ram_we = 1'b0;
    unique case (state_r)
      ST_IDLE: busy   = 1'b0;
      ST_DIV:  busy   = 1'b1;
      ST_READ: ram_re = 1'b1;
      ST_EXEC: ram_we = row_st.wr_en;
      default: busy   = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EXEC);
      if (ram_we) begin
        valid_r[bucket_r] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (state_r == ST_READ) begin
      bucket_r <= bucket;
      row_ok_r <= valid_r[bucket];
    end
    if (state_r == ST_EXEC) begin
      out_data_r <= row_st.res;
    end
  end

  // key mod BUCKETS over the divide and read cycles
  bht_bucket u_bucket (
    .clk    (clk),
    .key    (req_r.key),
    .bucket (bucket)
  );

  // one row per word
  bht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bucket_r),
    .wdata (row_new),
    .re    (ram_re),
    .raddr (bucket),
    .rdata (ram_rdata)
  );

  // a row never written reads as all empty
  assign row_cur = row_ok_r ? row_t'(ram_rdata) : '0;

  bht_row u_row (
    .opcode  (req_r.opcode),
    .key     (req_r.key),
    .row_in  (row_cur),
    .row_out (row_new),
    .status  (row_st)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: test/bucketed_hash_table_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bucketed_hash_table_top_test
// self-checking bench for the bucketed hash table
// ----------------------------------------------------------------------------
// drives insert, search and remove commands through the start/busy port and
// predicts every result beat with a row-by-row copy of the table. a short
// directed run hits key zero, full rows, duplicates, row packing on remove,
// the largest key and the unused opcode. a random run then works a few hot
// buckets at a time so rows fill, overflow and drain, mixed with noise.
// ----------------------------------------------------------------------------
module bucketed_hash_table_top_test;
  import bht_pkg::*;

  // opcode value with no operation behind it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_CMDS = 1100;
  localparam int HOT_COUNT = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  // --------------------------------------------------------------------------
  // table tracker: keeps its own copy of every row and the queue of results
  // the block owes, in command order
  // --------------------------------------------------------------------------
  class bucket_table;
    key_t rows [BUCKETS][SLOTS];
    out_t due_results [$];
    int errors;
    int n_insert, n_search, n_remove, n_unused;
    int n_hit, n_full, n_miss, n_shift, n_checked;

    function new();
      foreach (rows[b, s]) rows[b][s] = '0;
    endfunction

    // note one accepted command beat and work out the result it owes
    function void take_command(in_t cmd);
      int unsigned b;
      int i, j;
      bit done;
      out_t res;
      b = cmd.key % BUCKETS;
      res = '0;
      done = 1'b0;
      case (cmd.opcode) inside
        OP_INSERT: begin
          n_insert++;
          for (i = 0; i < SLOTS && !done; i++) begin
            if (rows[b][i] == '0) begin
              rows[b][i] = cmd.key;
              res.probes = PROBES_W'(i + 1);
              res.success = 1'b1;
              done = 1'b1;
            end
          end
          if (!done) begin
            res.probes = PROBES_W'(SLOTS);
            n_full++;
          end else begin
            n_hit++;
          end
        end
        OP_SEARCH, OP_REMOVE: begin
          if (cmd.opcode == OP_SEARCH) n_search++;
          else n_remove++;
          for (i = 0; i < SLOTS && !done; i++) begin
            if (rows[b][i] == cmd.key) begin
              if (cmd.opcode == OP_REMOVE) begin
                rows[b][i] = '0;
                // pull the later occupied slots up one place
                for (j = i + 1; j < SLOTS; j++) begin
                  if (rows[b][j] == '0) break;
                  rows[b][j-1] = rows[b][j];
                  rows[b][j] = '0;
                  if (j == i + 1) n_shift++;
                end
              end
              res.probes = PROBES_W'(i + 1);
              res.success = 1'b1;
              done = 1'b1;
              n_hit++;
            end else if (rows[b][i] == '0) begin
              res.probes = PROBES_W'(i + 1);
              done = 1'b1;
              n_miss++;
            end
          end
          if (!done) begin
            res.probes = PROBES_W'(SLOTS);
            n_miss++;
          end
        end
        default: begin
          n_unused++;
        end
      endcase
      due_results.push_back(res);
    endfunction

    // compare one result beat with the oldest owed result
    function void check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got probes %0d success %0d",
                 $time, got.probes, got.success);
        errors++;
        return;
      end
      want = due_results.pop_front();
      n_checked++;
      if (got.probes !== want.probes) begin
        $display("%0t: probes mismatch, expected %0d, got %0d",
                 $time, want.probes, got.probes);
        errors++;
      end
      if (got.success !== want.success) begin
        $display("%0t: success mismatch, expected %0d, got %0d",
                 $time, want.success, got.success);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;

  bucket_table table_sb = new();
  int idle_cycles;

  bucketed_hash_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: every strobed beat is checked, the receiver never stalls
  always @(posedge clk) begin
    if (rst_n && out_valid) table_sb.check_result(out_data);
  end

  // watchdog: cycles with neither a command nor a result beat
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results still owed",
               $time, STALL_LIMIT, table_sb.due_results.size());
      $display("bucketed_hash_table_top test failed");
      $finish;
    end
  end

  function automatic in_t make_cmd(logic [OP_W-1:0] op, key_t k);
    in_t c;
    c.opcode = op;
    c.key = k;
    return c;
  endfunction

  // random key that lands in bucket b; now and then the smallest such key
  function automatic key_t key_in_bucket(int unsigned b);
    int unsigned m;
    if ($urandom_range(0, 31) == 0) m = 0;
    else m = $urandom_range(0, (32'h7fff_ffff - b) / BUCKETS);
    return key_t'(b + BUCKETS * m);
  endfunction

  // well-formed command on a hot bucket: searches and removes mostly aim
  // at keys that are really stored, so rows churn instead of just filling
  function automatic in_t hot_cmd(int unsigned b);
    int pick, used;
    key_t k;
    pick = $urandom_range(0, 99);
    used = 0;
    while (used < SLOTS && table_sb.rows[b][used] != '0) used++;
    if (used > 0 && $urandom_range(0, 9) < 7) k = table_sb.rows[b][$urandom_range(0, used - 1)];
    else k = key_in_bucket(b);
    if (pick < 42) return make_cmd(OP_INSERT, key_in_bucket(b));
    if (pick < 68) return make_cmd(OP_SEARCH, k);
    return make_cmd(OP_REMOVE, k);
  endfunction

  // one command beat: start stays high until the block takes it
  task automatic send_cmd(input in_t cmd);
    start <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
    table_sb.take_command(cmd);
  endtask

  // sender gap of a few cycles, skipped during the back-to-back stretch
  task automatic maybe_pause(input bit back_to_back);
    if (!back_to_back && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  initial begin
    in_t directed [$];
    int unsigned hot [HOT_COUNT];
    in_t cmd;
    int n;
    int h;

    // known values from time zero while reset is held low
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // key zero on an empty row: matches the first empty slot every time
    directed.push_back(make_cmd(OP_SEARCH, 0));
    directed.push_back(make_cmd(OP_INSERT, 0));
    directed.push_back(make_cmd(OP_REMOVE, 0));
    // fill row 0, then overflow it
    directed.push_back(make_cmd(OP_INSERT, 100));
    directed.push_back(make_cmd(OP_INSERT, 200));
    directed.push_back(make_cmd(OP_INSERT, 300));
    directed.push_back(make_cmd(OP_INSERT, 400));
    directed.push_back(make_cmd(OP_INSERT, 500));
    directed.push_back(make_cmd(OP_INSERT, 600));
    // key zero on a full row fails after probing every slot
    directed.push_back(make_cmd(OP_SEARCH, 0));
    directed.push_back(make_cmd(OP_REMOVE, 0));
    // hit in the middle, miss on a full row
    directed.push_back(make_cmd(OP_SEARCH, 300));
    directed.push_back(make_cmd(OP_SEARCH, 700));
    // remove from the middle packs the row, keys move up one slot
    directed.push_back(make_cmd(OP_REMOVE, 200));
    directed.push_back(make_cmd(OP_SEARCH, 400));
    directed.push_back(make_cmd(OP_SEARCH, 700));
    // duplicate key goes into the next empty slot
    directed.push_back(make_cmd(OP_INSERT, 300));
    directed.push_back(make_cmd(OP_REMOVE, 100));
    // largest key, removed twice so the second one misses
    directed.push_back(make_cmd(OP_INSERT, {KEY_W{1'b1}}));
    directed.push_back(make_cmd(OP_SEARCH, {KEY_W{1'b1}}));
    directed.push_back(make_cmd(OP_REMOVE, {KEY_W{1'b1}}));
    directed.push_back(make_cmd(OP_REMOVE, {KEY_W{1'b1}}));
    // unused opcode changes nothing
    directed.push_back(make_cmd(OP_UNUSED, {KEY_W{1'b1}}));
    foreach (directed[i]) begin
      maybe_pause(1'b0);
      send_cmd(directed[i]);
    end

    // random part: a handful of hot buckets, swapped every 150 commands;
    // bucket 0 always stays hot so key zero meets full rows too
    for (n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 150 == 0) begin
        hot[0] = 0;
        for (h = 1; h < HOT_COUNT; h++) hot[h] = $urandom_range(0, BUCKETS - 1);
      end
      if ($urandom_range(0, 99) < 6) begin
        // noise: any opcode, any key
        cmd = make_cmd(OP_W'($urandom_range(0, 3)), key_t'($urandom));
      end else begin
        cmd = hot_cmd(hot[$urandom_range(0, HOT_COUNT - 1)]);
      end
      maybe_pause(n >= 400 && n < 700);
      send_cmd(cmd);
    end

    // drain: wait for every owed result, then a few cycles for strays
    start <= 1'b0;
    while (table_sb.due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d inserts, %0d searches, %0d removes, %0d unused-opcode commands",
             table_sb.n_insert, table_sb.n_search, table_sb.n_remove, table_sb.n_unused);
    $display("%0d results checked: %0d hits, %0d misses, %0d full-row inserts, %0d packing removes",
             table_sb.n_checked, table_sb.n_hit, table_sb.n_miss, table_sb.n_full,
             table_sb.n_shift);
    if (table_sb.errors == 0) begin
      $display("bucketed_hash_table_top test passed");
    end else begin
      $display("bucketed_hash_table_top test failed");
    end
    $finish;
  end

endmodule
